@@ src/isort_pkg.sv @@
// ----------------------------------------------------------------------------
// isort_pkg
// shared types and constants for the insertion sorter: beat payloads and the
// queue entry passed from the front end to the sort chain
// ----------------------------------------------------------------------------
package isort_pkg;

   localparam int VALUE_WIDTH = 32;

   // input beat
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] sample_value;
      logic                          final_item;
   } req_type;

   // result beat
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] sorted_value;
      logic                          final_output;
      logic                          overflow;
   } rsp_type;

   // queued beat, tagged with the sort direction in force when it arrived
   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          final_item;
      logic                          ascending;
   } entry_type;

endpackage

@@ src/isort_front.sv @@
// ----------------------------------------------------------------------------
// isort_front
// accepts input beats, tags each with the current sort direction and holds
// them in a two-entry queue ahead of the sort chain
// ----------------------------------------------------------------------------
module isort_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  isort_pkg::req_type  req_data,
   output logic                q_valid,
   input  logic                q_ready,
   output isort_pkg::entry_type q_data
);
   import isort_pkg::*;

   localparam int DEPTH = 2;

   logic       ascending_ff, ascending_in;
   entry_type  slot_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;
   entry_type  push_entry;

   assign req_ready = (fill_ff != 2'(DEPTH));
   assign q_valid   = (fill_ff != 2'd0);
   assign q_data    = slot_ff[rd_ptr_ff];

   assign push = req_valid && req_ready;
   assign pop  = q_valid && q_ready;

   always_comb begin
      push_entry.value      = req_data.sample_value;
      push_entry.final_item = req_data.final_item;
      push_entry.ascending  = ascending_ff;

      ascending_in = csr_wr_en ? csr_wr_data : ascending_ff;
      wr_ptr_in    = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in    = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in      = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ascending_ff <= 1'b1;
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         fill_ff      <= 2'd0;
      end else begin
         ascending_ff <= ascending_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
      end
   end

   // queue storage, payload only
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 2'(DEPTH))
      else $error("queue fill out of range");

   assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'(DEPTH)) && !pop |=> !req_ready)
      else $error("full queue opened without a pop");

   assert property (@(posedge clock) disable iff (reset)
      (fill_ff == 2'd0) && push |=> q_valid)
      else $error("pushed beat not presented");

endmodule

@@ src/isort_chain.sv @@
// ----------------------------------------------------------------------------
// isort_chain
// systolic insertion chain: every cell compares with the incoming value at
// once, one value enters per cycle while loading; a final value turns the chain into a
// shift register that drains through the result register
// ----------------------------------------------------------------------------
module isort_chain #(
   parameter int MAX_ITEMS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  isort_pkg::entry_type q_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output isort_pkg::rsp_type   rsp_data
);
   import isort_pkg::*;

   localparam int CW     = $clog2(MAX_ITEMS + 1);
   localparam int LEVELS = $clog2(MAX_ITEMS);

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   state_type                     state_ff, state_in;
   logic signed [VALUE_WIDTH-1:0] cell_ff [MAX_ITEMS];
   logic signed [VALUE_WIDTH-1:0] cell_in [MAX_ITEMS];
   logic [CW-1:0]                 count_ff, count_in;
   logic                          dropped_ff, dropped_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_data_ff, rsp_data_in;

   logic [MAX_ITEMS-1:0] after_vec;
   logic [MAX_ITEMS-1:0] scan [LEVELS+1];
   logic                 full;
   logic                 pop;
   logic                 slot_free;

   assign q_ready   = (state_ff == ST_LOAD);
   assign pop       = q_valid && q_ready;
   assign full      = (count_ff == CW'(MAX_ITEMS));
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // per-cell compare: free cells and cells that must follow the new value
   always_comb begin
      for (int k = 0; k < MAX_ITEMS; k++) begin
         if (CW'(k) >= count_ff) begin
            after_vec[k] = 1'b1;
         end else if (q_data.ascending) begin
            after_vec[k] = cell_ff[k] > q_data.value;
         end else begin
            after_vec[k] = cell_ff[k] < q_data.value;
         end
      end
   end

   // parallel prefix or: scan[LEVELS][k] set when cell k lies at or past the slot
   always_comb begin
      scan[0] = after_vec;
      for (int l = 0; l < LEVELS; l++) begin
         for (int k = 0; k < MAX_ITEMS; k++) begin
            if (k >= (1 << l)) begin
               scan[l+1][k] = scan[l][k] | scan[l][k - (1 << l)];
            end else begin
               scan[l+1][k] = scan[l][k];
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      for (int k = 0; k < MAX_ITEMS; k++) begin
         cell_in[k] = cell_ff[k];
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (pop) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
                  for (int k = 0; k < MAX_ITEMS; k++) begin
                     if (scan[LEVELS][k]) begin
                        if (k > 0 && scan[LEVELS][(k > 0) ? k - 1 : 0]) begin
                           cell_in[k] = cell_ff[(k > 0) ? k - 1 : 0];
                        end else begin
                           cell_in[k] = q_data.value;
                        end
                     end
                  end
               end
               if (q_data.final_item) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (slot_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.sorted_value = cell_ff[0];
               rsp_data_in.final_output = (count_ff == CW'(1));
               rsp_data_in.overflow     = dropped_ff;
               count_in                 = count_ff - CW'(1);
               for (int k = 0; k < MAX_ITEMS - 1; k++) begin
                  cell_in[k] = cell_ff[k+1];
               end
               if (count_ff == CW'(1)) begin
                  state_in   = ST_LOAD;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      for (int k = 0; k < MAX_ITEMS; k++) begin
         cell_ff[k] <= cell_in[k];
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("chain count past capacity");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (count_ff != '0))
      else $error("draining an empty chain");

   assert property (@(posedge clock) disable iff (reset)
      pop && q_data.final_item |=> (state_ff == ST_DRAIN) && (count_ff != '0))
      else $error("final beat did not start a drain");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) && slot_free && (count_ff == CW'(1)) |=>
         rsp_valid && rsp_data.final_output && (state_ff == ST_LOAD) && !dropped_ff)
      else $error("last result not marked or run not closed");

endmodule

@@ src/insertion_sorter_top.sv @@
// ----------------------------------------------------------------------------
// insertion_sorter_top
// stable insertion sorter for signed 32-bit values with selectable direction
// ----------------------------------------------------------------------------
// Collects up to MAX_ITEMS signed values and returns them in sorted order
// when a beat marked final_item arrives; equal values leave in arrival order.
// csr_wr_data sets the direction (1 smallest first, 0 largest first, reset 1)
// and is sampled per beat as it is accepted. While loading, one value enters
// the insertion chain per cycle: every cell compares against the new value
// in parallel. A final beat is taken, then every stored value drains
// through the result register, at one rsp beat per cycle while rsp_ready
// is high; req beats are held off during the drain once the two-entry
// input queue fills.
// Values arriving at a full store are dropped and every rsp beat of that run
// carries overflow; final_output marks the last beat of a run.
// ----------------------------------------------------------------------------
module insertion_sorter_top #(
   parameter int MAX_ITEMS = 64
) (
   input  logic               clock,
   input  logic               reset,
   // direction register
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   // input beats
   input  logic               req_valid,
   output logic               req_ready,
   input  isort_pkg::req_type req_data,
   // result beats
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output isort_pkg::rsp_type rsp_data
);
   import isort_pkg::*;

   // queue between the front end and the chain
   logic      q_valid;
   logic      q_ready;
   entry_type q_data;

   // front end: direction register, beat tagging, input queue
   isort_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_data      (q_data)
   );

   // back end: insertion chain, drain control, result register
   isort_chain #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
